[rtl/ffs_pkg.sv]
package ffs_pkg;

    localparam int COEF_BITS       = 16;
    localparam int COEF_FRAC       = 14;
    localparam int COEF_REGS       = 8;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int ACC_GUARD       = 3;
    localparam int DEF_TAPS        = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    typedef struct packed {
        logic shift;
        logic advance;
    } pipe_ctrl_t;

endpackage

[rtl/ffs_coef_bank.sv]
module ffs_coef_bank
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     wr_en,
    input  logic [ffs_pkg::CFG_INDEX_BITS-1:0]       wr_index,
    input  logic [ffs_pkg::COEF_BITS-1:0]            wr_data,
    output logic signed [ffs_pkg::COEF_BITS-1:0]     coef [ffs_pkg::COEF_REGS]
);
    import ffs_pkg::*;

    logic signed [COEF_BITS-1:0] coef_reg [COEF_REGS];

    // writes beyond the last coefficient fall through without effect
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                if (wr_index == CFG_INDEX_BITS'(i))
                begin
                    coef_reg[i] <= wr_data;
                end
            end
        end
    end

    assign coef = coef_reg;

endmodule

[rtl/ffs_tap_line.sv]
module ffs_tap_line #(
    parameter int TAPS        = ffs_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS = ffs_pkg::DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffs_pkg::pipe_ctrl_t           ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0] win [TAPS]
);
    import ffs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] win_reg [TAPS];

    // entry 0 is the newest sample, entry k is k samples older
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = TAPS - 1; i > 0; i--)
            begin
                win_reg[i] <= win_reg[i-1];
            end
            win_reg[0] <= sample_in;
        end
    end

    assign win = win_reg;

endmodule

[rtl/ffs_mac.sv]
module ffs_mac #(
    parameter int TAPS        = ffs_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS = ffs_pkg::DEF_SAMPLE_BITS
)
(
    input  logic                                  clk,
    input  ffs_pkg::pipe_ctrl_t                   ctrl,
    input  logic signed [ffs_pkg::COEF_BITS-1:0]  coef [ffs_pkg::COEF_REGS],
    input  logic signed [SAMPLE_BITS-1:0]         win [TAPS],
    output logic signed [SAMPLE_BITS-1:0]         sample_out
);
    import ffs_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + ACC_GUARD;
    localparam int Y_W    = ACC_W - COEF_FRAC;
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

    logic signed [PROD_W-1:0]      prod_reg [TAPS];
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [Y_W-1:0]         y;
    logic signed [SAMPLE_BITS-1:0] sample_out_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    // multiplier bank
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                prod_reg[i] <= coef[i] * win[i];
            end
        end
    end

    // sum, round half up, saturate
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            acc = acc + ACC_W'(prod_reg[i]);
        end
        rnd = acc + HALF;
        y   = Y_W'(rnd >>> COEF_FRAC);
        priority if (y > Y_MAX)
        begin
            sample_out_next = SAMPLE_BITS'(Y_MAX);
        end
        else if (y < Y_MIN)
        begin
            sample_out_next = SAMPLE_BITS'(Y_MIN);
        end
        else
        begin
            sample_out_next = SAMPLE_BITS'(y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            sample_out_reg <= sample_out_next;
        end
    end

    assign sample_out = sample_out_reg;

endmodule

[rtl/fir_filter_stream_unit.sv]
// fir_filter_stream_unit: direct-form FIR filter over a stream of signed samples
//
// input channel: in_valid / in_ready with sample_in, one transaction per sample
// output channel: out_valid / out_ready with sample_out, one result per sample
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index i
//   writes coefficient i (signed Q2.14), indexes of 8 and above are ignored;
//   cfg_ready is always high, write only while the filter is idle
// result: sum of coef_i * x[n-i] over TAPS taps, rounded half up, saturated
// pipeline: the tap line loads on the input transaction, then the multiplier
//   and result registers follow before out_valid
// throughput: one sample per cycle while the output is not stalled; one product per tap in parallel
// reset: coefficients and sample history clear to zero, pipeline empties
// stall: while out_valid is high and out_ready is low the whole pipeline
//   holds and in_ready drops; history is kept, nothing is lost
module fir_filter_stream_unit #(
    parameter int TAPS        = ffs_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS = ffs_pkg::DEF_SAMPLE_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ffs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ffs_pkg::COEF_BITS-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_BITS-1:0]        sample_out
);
    import ffs_pkg::*;

    logic                          win_valid_reg;
    logic                          prod_valid_reg;
    logic                          out_valid_reg;
    logic                          advance;
    logic                          accept;
    pipe_ctrl_t                    ctrl;
    logic signed [COEF_BITS-1:0]   coef [COEF_REGS];
    logic signed [SAMPLE_BITS-1:0] win [TAPS];

    assign cfg_ready    = 1'b1;
    assign advance      = !out_valid_reg || out_ready;
    assign in_ready     = advance;
    assign accept       = in_valid && advance;
    assign ctrl.shift   = accept;
    assign ctrl.advance = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            win_valid_reg  <= accept;
            prod_valid_reg <= win_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    ffs_coef_bank u_coef_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coef     (coef)
    );

    ffs_tap_line #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tap_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample_in (sample_in),
        .win       (win)
    );

    ffs_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk        (clk),
        .ctrl       (ctrl),
        .coef       (coef),
        .win        (win),
        .sample_out (sample_out)
    );

    // accepted sample lands at the head of the tap line
    a_shift_head: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> win_valid_reg && win[0] == $past(sample_in))
        else $error("tap line head does not hold the accepted sample");

    // the tap line stage passes its data on whenever the pipeline moves
    a_prod_follow: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid_reg && advance |=> prod_valid_reg)
        else $error("multiplier stage dropped a transaction");

    // backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

    // a stalled result register keeps its transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("result changed while stalled");

endmodule

[dv/fir_filter_stream_unit_test.sv]
`timescale 1ns / 100ps

module fir_filter_stream_unit_test;

    localparam int SAMPLE_BITS    = ffs_pkg::DEF_SAMPLE_BITS;
    localparam int TAPS           = ffs_pkg::DEF_TAPS;
    localparam int COEF_BITS      = ffs_pkg::COEF_BITS;
    localparam int COEF_REGS      = ffs_pkg::COEF_REGS;
    localparam int INDEX_BITS     = ffs_pkg::CFG_INDEX_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_OFF       = 300;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 94;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = 16'sh7fff;
    localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = 16'sh8000;
    localparam logic signed [COEF_BITS-1:0]   COEF_ONE   = 16'sh4000;
    localparam logic signed [COEF_BITS-1:0]   COEF_LSB   = 16'sh0001;

    class fir_output_scoreboard;
        logic signed [COEF_BITS-1:0]   coefs [COEF_REGS];
        logic signed [SAMPLE_BITS-1:0] history [TAPS-1];
        logic signed [SAMPLE_BITS-1:0] expected_samples [$];
        int errors;

        function new();
            foreach (coefs[i])
                coefs[i] = '0;
            foreach (history[i])
                history[i] = '0;
            errors = 0;
        endfunction

        function void write_coef(logic [INDEX_BITS-1:0] index, logic [COEF_BITS-1:0] data);
            // indexes past the coefficient bank are dropped
            if (index < COEF_REGS)
                coefs[index] = data;
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] x);
            longint acc;
            longint y;
            acc = longint'(coefs[0]) * longint'(x);
            for (int i = 1; i < TAPS; i++)
                acc += longint'(coefs[i]) * longint'(history[i-1]);
            // round half up, then saturate
            y = (acc + (longint'(1) << (ffs_pkg::COEF_FRAC - 1))) >>> ffs_pkg::COEF_FRAC;
            if (y > longint'(SAMPLE_MAX))
                y = longint'(SAMPLE_MAX);
            if (y < longint'(SAMPLE_MIN))
                y = longint'(SAMPLE_MIN);
            for (int i = TAPS - 2; i > 0; i--)
                history[i] = history[i-1];
            history[0] = x;
            expected_samples.push_back(SAMPLE_BITS'(y));
        endfunction

        function void check_sample(logic signed [SAMPLE_BITS-1:0] actual);
            logic signed [SAMPLE_BITS-1:0] expected;
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: unexpected transaction, actual %0d", actual);
                errors++;
            end
            else
            begin
                expected = expected_samples.pop_front();
                if (actual !== expected)
                begin
                    $error("sample_out: expected %0d, actual %0d", expected, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [INDEX_BITS-1:0]         cfg_index = '0;
    logic [COEF_BITS-1:0]          cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    fir_output_scoreboard board = new();
    logic signed [COEF_BITS-1:0] coef_plan [COEF_REGS];
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    fir_filter_stream_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // transaction monitor
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            board.write_coef(cfg_index, cfg_data);
        if (in_valid && in_ready)
            board.note_sample(sample_in);
        if (out_valid && out_ready)
            board.check_sample(sample_out);
    end

    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // output side: long hold-off on request, random stalls otherwise
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic program_coefs(input int spare_count);
        int spare;
        for (int i = 0; i < COEF_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= INDEX_BITS'(i);
            cfg_data  <= coef_plan[i];
            do @(posedge clk); while (!cfg_ready);
        end
        // writes past the bank go last so a wrapped index would clobber a tap
        for (int k = 0; k < spare_count; k++)
        begin
            spare = (spare_count == COEF_REGS) ? k : $urandom_range(COEF_REGS - 1);
            cfg_valid <= 1'b1;
            cfg_index <= INDEX_BITS'(COEF_REGS + spare);
            cfg_data  <= COEF_BITS'($urandom);
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        // let the monitor record the last transaction first
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] r;
        r = SAMPLE_BITS'($urandom);
        case ($urandom_range(9))
            0: case ($urandom_range(3))
                   0: return SAMPLE_MAX;
                   1: return SAMPLE_MIN;
                   2: return '0;
                   default: return '1;
               endcase
            1, 2: return {{7{r[8]}}, r[8:0]};
            default: return r;
        endcase
    endfunction

    function automatic logic signed [COEF_BITS-1:0] pick_coef(input int mode);
        logic [COEF_BITS-1:0] r;
        r = COEF_BITS'($urandom);
        if (mode == 3)
            mode = $urandom_range(2);
        case (mode)
            0: return r;
            1: return {{5{r[11]}}, r[10:0]};
            default: case ($urandom_range(3))
                         0: return COEF_MAX;
                         1: return COEF_MIN;
                         2: return '0;
                         default: return COEF_ONE;
                     endcase
        endcase
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // impulse walks through every tap, history starts out cleared
        coef_plan = '{COEF_ONE, -COEF_ONE, 16'sh2000, COEF_LSB, -COEF_LSB,
                      COEF_MAX, COEF_MIN, 16'sh1000};
        program_coefs(COEF_REGS);
        send_sample(SAMPLE_MAX);
        repeat (TAPS - 1) send_sample('0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('1);
        send_sample(16'sh0001);
        send_sample(16'sh5555);
        drain();

        // saturation at both rails
        foreach (coef_plan[i])
            coef_plan[i] = COEF_MIN;
        program_coefs(1);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        repeat (4) send_sample(SAMPLE_MAX);
        drain();

        // exact halfway values round up
        foreach (coef_plan[i])
            coef_plan[i] = '0;
        coef_plan[0] = COEF_LSB;
        program_coefs(1);
        send_sample(16'sh2000);
        send_sample(-16'sh2000);
        send_sample(16'sh6000);
        send_sample(-16'sh6000);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            foreach (coef_plan[i])
                coef_plan[i] = pick_coef((p + p / 4) % 4);
            program_coefs($urandom_range(2));
            if (p == 0)
                hold_left = HOLD_OFF;
            for (int n = 0; n < PHASE_SAMPLES; n++)
                send_sample(pick_sample());
            drain();
        end

        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
